@@ sv/scale3x_pixel_upscaler_assert.svh @@
// Assertion macros for the Scale3x upscaler port checker.
// Depends on nothing; the including module must provide clk and rst_n.
`ifndef SCALE3X_PIXEL_UPSCALER_ASSERT_SVH
`define SCALE3X_PIXEL_UPSCALER_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define S3X_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define S3X_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/s3x_pkg.sv @@
// Shared types, constants and the Scale3x block function for the upscaler.
// Depends on nothing; used by every module of the block.
`default_nettype none

package s3x_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int SIZE_W     = 11;
    localparam int CFG_IDX_W  = 1;
    localparam int NUM_SLOTS  = 4;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    typedef logic [7:0]           pix_t;
    typedef logic [COL_W-1:0]     col_t;
    typedef logic [ROW_W-1:0]     row_t;
    typedef logic [SIZE_W-1:0]    size_t;
    typedef logic [NUM_SLOTS-1:0] slot_mask_t;
    typedef pix_t [2:0]           trio_t;
    typedef trio_t [2:0]          win_t;
    typedef pix_t [8:0]           blk_t;

    typedef struct packed {
        win_t       win;
        col_t       col;
        row_t       row;
        slot_mask_t mask;
    } job_t;

    typedef struct packed {
        logic we;
        col_t addr;
        pix_t up;
        pix_t mid;
    } line_wr_t;

    function automatic size_t clamp_size(input size_t v, input size_t max_v);
        size_t r;
        if (v == '0) begin
            r = size_t'(1);
        end
        else if (v > max_v) begin
            r = max_v;
        end
        else begin
            r = v;
        end
        return r;
    endfunction

    function automatic blk_t scale3x_block(input pix_t a, input pix_t b, input pix_t c,
                                           input pix_t d, input pix_t e, input pix_t f,
                                           input pix_t g, input pix_t h, input pix_t i);
        logic db;
        logic bf;
        logic hd;
        logic fh;
        blk_t o;
        db = (d == b) && (d != h) && (b != f);
        bf = (b == f) && (b != d) && (f != h);
        hd = (h == d) && (h != f) && (d != b);
        fh = (f == h) && (f != b) && (h != d);
        o[0] = db ? d : e;
        o[1] = ((db && (e != c)) || (bf && (e != a))) ? b : e;
        o[2] = bf ? f : e;
        o[3] = ((hd && (e != a)) || (db && (e != g))) ? d : e;
        o[4] = e;
        o[5] = ((bf && (e != i)) || (fh && (e != c))) ? f : e;
        o[6] = hd ? d : e;
        o[7] = ((fh && (e != g)) || (hd && (e != i))) ? h : e;
        o[8] = fh ? f : e;
        return o;
    endfunction

endpackage

`default_nettype wire

@@ sv/scale3x_pixel_upscaler.sv @@
// Top level of the Scale3x pixel upscaler: counters, line buffer read stage and window.
// Depends on s3x_pkg, s3x_line_store and s3x_block_emit.
//
// Source pixels enter in raster order. While the output is not stalled, one item enters
// per clock when each causes at most one result and the emitter sends one 3x3 output
// block per cycle; an item that closes two to four blocks (last column or last row) holds
// the input until its last block is sent. An item's first result passes the stage-one,
// emitter job and output registers. The two line buffers are 1024-entry memories with
// one read and one write per cycle and need no clearing after reset. Image width and
// height are written by the user through the configuration port only while the block
// is idle; the block does not enforce it. Zero acts as one, values above 1024 as 1024.
`default_nettype none

module scale3x_pixel_upscaler (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [s3x_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire s3x_pkg::size_t                   cfg_data,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire s3x_pkg::pix_t                    pixel,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output s3x_pkg::pix_t                         top_left,
    output s3x_pkg::pix_t                         top_mid,
    output s3x_pkg::pix_t                         top_right,
    output s3x_pkg::pix_t                         mid_left,
    output s3x_pkg::pix_t                         center,
    output s3x_pkg::pix_t                         mid_right,
    output s3x_pkg::pix_t                         bot_left,
    output s3x_pkg::pix_t                         bot_mid,
    output s3x_pkg::pix_t                         bot_right,
    output s3x_pkg::col_t                         src_col,
    output s3x_pkg::row_t                         src_row,
    output logic                                  last_of_run
);
    import s3x_pkg::*;

    size_t      width_reg;
    size_t      height_reg;
    col_t       col_count_reg;
    row_t       row_count_reg;
    col_t       col_count_next;
    row_t       row_count_next;
    win_t       win_reg;
    win_t       win_next;

    logic       s1_valid_reg;
    pix_t       s1_pixel_reg;
    col_t       s1_col_reg;
    row_t       s1_row_reg;
    logic       s1_last_col_reg;
    logic       s1_last_row_reg;

    size_t      w_eff;
    size_t      h_eff;
    logic       last_col;
    logic       last_row;
    logic       in_fire;
    logic       s1_adv;
    logic       emit_free;
    pix_t       rd_up;
    pix_t       rd_mid;
    pix_t       up_v;
    pix_t       mid_v;
    slot_mask_t mask;
    line_wr_t   line_wr;
    job_t       job;
    blk_t       out_blk;

    assign w_eff    = clamp_size(width_reg, size_t'(MAX_WIDTH));
    assign h_eff    = clamp_size(height_reg, size_t'(MAX_HEIGHT));
    assign last_col = (size_t'(col_count_reg) + size_t'(1)) >= w_eff;
    assign last_row = (size_t'(row_count_reg) + size_t'(1)) >= h_eff;

    assign in_ready = !s1_valid_reg || s1_adv;
    assign in_fire  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= size_t'(1);
            height_reg <= size_t'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        if (last_col)
        begin
            col_count_next = '0;
            row_count_next = last_row ? '0 : row_count_reg + row_t'(1);
        end
        else
        begin
            col_count_next = col_count_reg + col_t'(1);
            row_count_next = last_row ? row_t'(h_eff - size_t'(1)) : row_count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= '0;
            row_count_reg <= '0;
            s1_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                col_count_reg <= col_count_next;
                row_count_reg <= row_count_next;
            end
            if (in_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_pixel_reg    <= pixel;
            s1_col_reg      <= col_count_reg;
            s1_row_reg      <= row_count_reg;
            s1_last_col_reg <= last_col;
            s1_last_row_reg <= last_row;
        end
    end

    s3x_line_store u_line_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (in_fire),
        .rd_addr (col_count_reg),
        .wr      (line_wr),
        .rd_up   (rd_up),
        .rd_mid  (rd_mid)
    );

    always_comb
    begin
        if (s1_row_reg == '0)
        begin
            up_v  = s1_pixel_reg;
            mid_v = s1_pixel_reg;
        end
        else if (s1_row_reg == row_t'(1))
        begin
            up_v  = rd_mid;
            mid_v = rd_mid;
        end
        else
        begin
            up_v  = rd_up;
            mid_v = rd_mid;
        end

        if (s1_col_reg == '0)
        begin
            win_next[0] = {3{up_v}};
            win_next[1] = {3{mid_v}};
            win_next[2] = {3{s1_pixel_reg}};
        end
        else
        begin
            win_next[0] = {up_v,         win_reg[0][2], win_reg[0][1]};
            win_next[1] = {mid_v,        win_reg[1][2], win_reg[1][1]};
            win_next[2] = {s1_pixel_reg, win_reg[2][2], win_reg[2][1]};
        end

        mask[0] = (s1_row_reg != '0) && (s1_col_reg != '0);
        mask[1] = (s1_row_reg != '0) && s1_last_col_reg;
        mask[2] = s1_last_row_reg && (s1_col_reg != '0);
        mask[3] = s1_last_row_reg && s1_last_col_reg;
    end

    assign s1_adv = s1_valid_reg && ((mask == '0) || emit_free);

    assign line_wr.we   = s1_adv;
    assign line_wr.addr = s1_col_reg;
    assign line_wr.up   = mid_v;
    assign line_wr.mid  = s1_pixel_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= '0;
        end
        else if (s1_adv)
        begin
            win_reg <= win_next;
        end
    end

    assign job.win  = win_next;
    assign job.col  = s1_col_reg;
    assign job.row  = s1_row_reg;
    assign job.mask = mask;

    s3x_block_emit u_block_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (s1_adv && (mask != '0)),
        .job_in    (job),
        .free      (emit_free),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_blk   (out_blk),
        .out_col   (src_col),
        .out_row   (src_row),
        .out_last  (last_of_run)
    );

    assign top_left  = out_blk[0];
    assign top_mid   = out_blk[1];
    assign top_right = out_blk[2];
    assign mid_left  = out_blk[3];
    assign center    = out_blk[4];
    assign mid_right = out_blk[5];
    assign bot_left  = out_blk[6];
    assign bot_mid   = out_blk[7];
    assign bot_right = out_blk[8];

endmodule

`default_nettype wire

@@ sv/s3x_line_store.sv @@
// Two line buffers (rows r-2 and r-1) in synchronous memories with registered reads.
// A write to the address read in the same cycle is forwarded. Depends on s3x_pkg.
`default_nettype none

module s3x_line_store (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              rd_en,
    input  wire s3x_pkg::col_t     rd_addr,
    input  wire s3x_pkg::line_wr_t wr,
    output s3x_pkg::pix_t          rd_up,
    output s3x_pkg::pix_t          rd_mid
);
    import s3x_pkg::*;

    pix_t up_mem  [MAX_WIDTH];
    pix_t mid_mem [MAX_WIDTH];
    pix_t up_q_reg;
    pix_t mid_q_reg;
    pix_t fwd_up_reg;
    pix_t fwd_mid_reg;
    logic fwd_reg;

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            up_mem[wr.addr]  <= wr.up;
            mid_mem[wr.addr] <= wr.mid;
        end
        if (rd_en)
        begin
            up_q_reg    <= up_mem[rd_addr];
            mid_q_reg   <= mid_mem[rd_addr];
            fwd_up_reg  <= wr.up;
            fwd_mid_reg <= wr.mid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            fwd_reg <= wr.we && (wr.addr == rd_addr);
        end
    end

    assign rd_up  = fwd_reg ? fwd_up_reg  : up_q_reg;
    assign rd_mid = fwd_reg ? fwd_mid_reg : mid_q_reg;

endmodule

`default_nettype wire

@@ sv/s3x_block_emit.sv @@
// Holds one item's window and sends out its pending Scale3x blocks, one per cycle while
// the output is not stalled, through an output register. Depends on s3x_pkg.
`default_nettype none

module s3x_block_emit (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          load,
    input  wire s3x_pkg::job_t job_in,
    output logic               free,
    input  wire logic          out_ready,
    output logic               out_valid,
    output s3x_pkg::blk_t      out_blk,
    output s3x_pkg::col_t      out_col,
    output s3x_pkg::row_t      out_row,
    output logic               out_last
);
    import s3x_pkg::*;

    job_t       job_reg;
    slot_mask_t mask_reg;
    logic       job_valid_reg;
    logic       out_valid_reg;
    blk_t       blk_reg;
    col_t       col_reg;
    row_t       row_reg;
    logic       last_reg;

    slot_mask_t pick;
    slot_mask_t rest;
    logic       emit_fire;
    logic       job_done;
    logic       lower;
    logic       right;
    logic [1:0] ri0;
    logic [1:0] ri1;
    logic [1:0] ci0;
    logic [1:0] ci1;
    blk_t       blk_next;
    col_t       col_next;
    row_t       row_next;

    assign pick      = mask_reg & (~mask_reg + slot_mask_t'(1));
    assign rest      = mask_reg & ~pick;
    assign emit_fire = job_valid_reg && (!out_valid_reg || out_ready);
    assign job_done  = emit_fire && (rest == '0);
    assign free      = !job_valid_reg || job_done;

    assign lower = pick[2] | pick[3];
    assign right = pick[1] | pick[3];

    always_comb
    begin
        ri0 = lower ? 2'd1 : 2'd0;
        ri1 = lower ? 2'd2 : 2'd1;
        ci0 = right ? 2'd1 : 2'd0;
        ci1 = right ? 2'd2 : 2'd1;
        blk_next = scale3x_block(job_reg.win[ri0][ci0], job_reg.win[ri0][ci1],
                                 job_reg.win[ri0][2], job_reg.win[ri1][ci0],
                                 job_reg.win[ri1][ci1], job_reg.win[ri1][2],
                                 job_reg.win[2][ci0], job_reg.win[2][ci1],
                                 job_reg.win[2][2]);
        col_next = right ? job_reg.col : job_reg.col - col_t'(1);
        row_next = lower ? job_reg.row : job_reg.row - row_t'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                job_valid_reg <= 1'b1;
                mask_reg      <= job_in.mask;
            end
            else if (job_done)
            begin
                job_valid_reg <= 1'b0;
                mask_reg      <= '0;
            end
            else if (emit_fire)
            begin
                mask_reg <= rest;
            end

            if (emit_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            job_reg <= job_in;
        end
        if (emit_fire)
        begin
            blk_reg  <= blk_next;
            col_reg  <= col_next;
            row_reg  <= row_next;
            last_reg <= (rest == '0);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_blk   = blk_reg;
    assign out_col   = col_reg;
    assign out_row   = row_reg;
    assign out_last  = last_reg;

endmodule

`default_nettype wire

@@ sv/s3x_port_check.sv @@
// Port-level checker for the Scale3x upscaler, attached to the top level by bind.
// Depends on s3x_pkg and the assertion macros in scale3x_pixel_upscaler_assert.svh.
`default_nettype none

`include "scale3x_pixel_upscaler_assert.svh"

module s3x_port_check (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_ready,
    input  wire logic                             out_valid,
    input  wire logic                             out_ready,
    input  wire s3x_pkg::col_t                    src_col,
    input  wire s3x_pkg::row_t                    src_row,
    input  wire logic                             last_of_run
);
    import s3x_pkg::*;

    // A stalled result keeps its position and its run marker.
    `S3X_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(src_col) && $stable(src_row) && $stable(last_of_run),
        "result changed while stalled")

    // The blocks of one item follow each other without a gap.
    `S3X_ASSERT_NEXT(a_run_continues, out_valid && out_ready && !last_of_run,
        out_valid, "gap inside a run of blocks")

    // Within one run the source row stays or moves down by one.
    `S3X_ASSERT_NEXT(a_run_rows, out_valid && out_ready && !last_of_run,
        (src_row == $past(src_row)) || (src_row == ($past(src_row) + row_t'(1))),
        "row jump inside a run of blocks")

    // The handshake outputs are always driven to a known level once out of reset.
    `S3X_ASSERT_SAME(a_handshake_known, 1'b1,
        !$isunknown({in_ready, out_valid}), "unknown handshake output")

endmodule

bind scale3x_pixel_upscaler s3x_port_check u_port_check (.*);

`default_nettype wire
